>>> sv/cau_pkg.sv
package cau_pkg;

   // Command codes as they arrive on the request port.
   localparam logic [2:0] CMD_SUB   = 3'd0;
   localparam logic [2:0] CMD_MUL   = 3'd1;
   localparam logic [2:0] CMD_DIV   = 3'd2;
   localparam logic [2:0] CMD_POLAR = 3'd3;
   localparam logic [2:0] CMD_NE    = 3'd4;

   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_DIV_ZERO = 2'd1;
   localparam logic [1:0] STATUS_SAT      = 2'd2;

   typedef enum logic [2:0] {
      OP_SUB   = 3'd0,
      OP_MUL   = 3'd1,
      OP_DIV   = 3'd2,
      OP_POLAR = 3'd3,
      OP_NE    = 3'd4,
      OP_NONE  = 3'd5
   } op_type;

   typedef struct packed {
      op_type op;
      logic   differs;
      logic   dz;
   } ctl_type;

   typedef struct packed {
      logic [31:0] q;
      logic        sat;
   } q16_type;

   // Quotient bits, root bits and the number of shared iteration stages.
   localparam int DIV_QBITS = 33;
   localparam int SQRT_BITS = 31;
   localparam int NSTEP     = 33;

   localparam logic signed [31:0] HALF_PI_Q16 = 32'sd102944;

   // atan(2^-i) in Q16.16.
   localparam logic signed [31:0] ATAN_TAB [32] = '{
      32'sd51472, 32'sd30386, 32'sd16055, 32'sd8150, 32'sd4091, 32'sd2047, 32'sd1024, 32'sd512,
      32'sd256, 32'sd128, 32'sd64, 32'sd32, 32'sd16, 32'sd8, 32'sd4, 32'sd2,
      32'sd1, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0,
      32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0
   };

   // Brings a signed value with frac fraction bits to Q16.16, truncating toward
   // zero and saturating to the 32-bit range.
   function automatic q16_type scale_q16(input logic signed [95:0] v, input int unsigned frac);
      logic signed [95:0] t;
      logic signed [95:0] bias;
      q16_type r;
      if (frac < 16) begin
         t = v <<< (16 - frac);
      end else begin
         bias = v[95] ? ((96'sd1 <<< (frac - 16)) - 96'sd1) : 96'sd0;
         t = (v + bias) >>> (frac - 16);
      end
      if (t > 96'sd2147483647) begin
         r.q = 32'h7FFF_FFFF;
         r.sat = 1'b1;
      end else if (t < -96'sd2147483648) begin
         r.q = 32'h8000_0000;
         r.sat = 1'b1;
      end else begin
         r.q = t[31:0];
         r.sat = 1'b0;
      end
      return r;
   endfunction

endpackage

>>> sv/cau_front.sv
module cau_front #(
   parameter int IN_WIDTH = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  logic [2:0]                 req_cmd,
   input  logic signed [IN_WIDTH-1:0] req_a_re,
   input  logic signed [IN_WIDTH-1:0] req_a_im,
   input  logic signed [IN_WIDTH-1:0] req_b_re,
   input  logic signed [IN_WIDTH-1:0] req_b_im,
   input  logic                       q_full,
   output logic                       push,
   output cau_pkg::ctl_type           push_ctl,
   output logic [4*IN_WIDTH-1:0]      push_opnd
);
   import cau_pkg::*;

   logic                  vld_ff, vld_in;
   ctl_type               ctl_ff, ctl_in;
   ctl_type               dec;
   logic [4*IN_WIDTH-1:0] opnd_ff, opnd_in;
   logic                  accept;

   assign busy   = vld_ff && q_full;
   assign push   = vld_ff && !q_full;
   assign accept = start && !busy;

   always_comb begin
      unique case (req_cmd)
         CMD_SUB:   dec.op = OP_SUB;
         CMD_MUL:   dec.op = OP_MUL;
         CMD_DIV:   dec.op = OP_DIV;
         CMD_POLAR: dec.op = OP_POLAR;
         CMD_NE:    dec.op = OP_NE;
         default:   dec.op = OP_NONE;
      endcase
      dec.differs = (req_a_re != req_b_re) || (req_a_im != req_b_im);
      dec.dz      = (req_b_re == '0) && (req_b_im == '0);
   end

   assign vld_in  = accept ? 1'b1 : (push ? 1'b0 : vld_ff);
   assign ctl_in  = accept ? dec : ctl_ff;
   assign opnd_in = accept ? {req_a_re, req_a_im, req_b_re, req_b_im} : opnd_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      ctl_ff  <= ctl_in;
      opnd_ff <= opnd_in;
   end

   assign push_ctl  = ctl_ff;
   assign push_opnd = opnd_ff;

endmodule

>>> sv/cau_queue.sv
module cau_queue #(
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   output logic             pop_valid,
   output logic [WIDTH-1:0] pop_data
);
   localparam int DEPTH = 2;
   localparam int AW    = $clog2(DEPTH);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [AW-1:0]    wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [AW:0]      cnt_ff, cnt_in;
   logic             pop;

   // The back end never stalls, so an item leaves as soon as it is here.
   assign pop       = (cnt_ff != '0);
   assign full      = (cnt_ff == (AW+1)'(DEPTH));
   assign pop_valid = pop;
   assign pop_data  = mem_ff[rd_ptr_ff];

   assign wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
   assign rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
   assign cnt_in    = cnt_ff + (AW+1)'(push) - (AW+1)'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

>>> sv/cau_back.sv
module cau_back #(
   parameter int IN_WIDTH     = 16,
   parameter int FRAC_BITS    = 8,
   parameter int CORDIC_STEPS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   input  cau_pkg::ctl_type      in_ctl,
   input  logic [4*IN_WIDTH-1:0] in_opnd,
   output logic                  rsp_valid,
   output logic [31:0]           rsp_res_re,
   output logic [31:0]           rsp_res_im,
   output logic                  rsp_differs,
   output logic [1:0]            rsp_status
);
   import cau_pkg::*;

   localparam int IW = IN_WIDTH;
   localparam int MW = 2*IW;
   localparam int PW = MW + 1;
   localparam int NW = PW + 16;
   localparam int DW = PW + DIV_QBITS;
   localparam int XW = IW + 1;
   localparam int CW = IW + 19;
   localparam int VW = NSTEP + 4;

   typedef struct packed {
      ctl_type                ctl;
      logic signed [MW-1:0]   rr, ii, ri, ir, sbr, sbi, sar, sai;
      logic signed [XW-1:0]   dr, di;
      logic                   zero;
      logic signed [CW-1:0]   cx, cy;
      logic signed [31:0]     cz;
   } p1_type;

   typedef struct packed {
      ctl_type                ctl;
      q16_type                sub_re, sub_im;
      logic signed [PW-1:0]   mre, mim, nre, nim;
      logic [PW-1:0]          den, psum;
      logic                   zero;
      logic signed [CW-1:0]   cx, cy;
      logic signed [31:0]     cz;
   } p2_type;

   typedef struct packed {
      ctl_type                ctl;
      logic [31:0]            s_re, s_im;
      logic                   s_sat;
      logic                   neg_re, neg_im, ovf_re, ovf_im;
      logic [NW-1:0]          rem_re, rem_im;
      logic [DIV_QBITS-1:0]   q_re, q_im;
      logic [PW-1:0]          den;
      logic                   big;
      logic [63:0]            srem;
      logic [SQRT_BITS-1:0]   root;
      logic                   zero;
      logic signed [CW-1:0]   cx, cy;
      logic signed [31:0]     cz;
   } loop_type;

   logic signed [IW-1:0] a_re, a_im, b_re, b_im;
   logic signed [XW-1:0] xr, yr;
   p1_type               p1_ff, p1_in;
   p2_type               p2_ff, p2_in;
   loop_type             st_ff [NSTEP+1];
   loop_type             st_in [NSTEP+1];
   logic [VW-1:0]        vld_ff, vld_in;
   logic [31:0]          re_ff, re_in, im_ff, im_in;
   logic                 dif_ff, dif_in;
   logic [1:0]           sts_ff, sts_in;

   assign a_re = in_opnd[4*IW-1 -: IW];
   assign a_im = in_opnd[3*IW-1 -: IW];
   assign b_re = in_opnd[2*IW-1 -: IW];
   assign b_im = in_opnd[IW-1 -: IW];

   // Products, differences and the quadrant fold for the angle.
   always_comb begin
      p1_in.ctl = in_ctl;
      p1_in.rr  = MW'(a_re) * MW'(b_re);
      p1_in.ii  = MW'(a_im) * MW'(b_im);
      p1_in.ri  = MW'(a_re) * MW'(b_im);
      p1_in.ir  = MW'(a_im) * MW'(b_re);
      p1_in.sbr = MW'(b_re) * MW'(b_re);
      p1_in.sbi = MW'(b_im) * MW'(b_im);
      p1_in.sar = MW'(a_re) * MW'(a_re);
      p1_in.sai = MW'(a_im) * MW'(a_im);
      p1_in.dr  = XW'(a_re) - XW'(b_re);
      p1_in.di  = XW'(a_im) - XW'(b_im);
      p1_in.zero = (a_re == '0) && (a_im == '0);
      if (a_re[IW-1] && !a_im[IW-1]) begin
         xr = XW'(a_im);
         yr = -XW'(a_re);
         p1_in.cz = HALF_PI_Q16;
      end else if (a_re[IW-1]) begin
         xr = -XW'(a_im);
         yr = XW'(a_re);
         p1_in.cz = -HALF_PI_Q16;
      end else begin
         xr = XW'(a_re);
         yr = XW'(a_im);
         p1_in.cz = '0;
      end
      p1_in.cx = CW'(xr) <<< 16;
      p1_in.cy = CW'(yr) <<< 16;
   end

   always_comb begin
      p2_in.ctl    = p1_ff.ctl;
      p2_in.sub_re = scale_q16(96'(p1_ff.dr), FRAC_BITS);
      p2_in.sub_im = scale_q16(96'(p1_ff.di), FRAC_BITS);
      p2_in.mre    = PW'(p1_ff.rr) - PW'(p1_ff.ii);
      p2_in.mim    = PW'(p1_ff.ri) + PW'(p1_ff.ir);
      p2_in.nre    = PW'(p1_ff.rr) + PW'(p1_ff.ii);
      p2_in.nim    = PW'(p1_ff.ir) - PW'(p1_ff.ri);
      p2_in.den    = PW'(p1_ff.sbr) + PW'(p1_ff.sbi);
      p2_in.psum   = PW'(p1_ff.sar) + PW'(p1_ff.sai);
      p2_in.zero   = p1_ff.zero;
      p2_in.cx     = p1_ff.cx;
      p2_in.cy     = p1_ff.cy;
      p2_in.cz     = p1_ff.cz;
   end

   // Preparation: scale the product results, set up divider and root.
   always_comb begin
      q16_type          mq_re, mq_im;
      logic [PW-1:0]    mag_re, mag_im;
      logic [63:0]      p64;
      mq_re  = scale_q16(96'(p2_ff.mre), 2*FRAC_BITS);
      mq_im  = scale_q16(96'(p2_ff.mim), 2*FRAC_BITS);
      mag_re = p2_ff.nre[PW-1] ? PW'(-p2_ff.nre) : PW'(p2_ff.nre);
      mag_im = p2_ff.nim[PW-1] ? PW'(-p2_ff.nim) : PW'(p2_ff.nim);
      p64    = 64'(p2_ff.psum);
      st_in[0].ctl = p2_ff.ctl;
      if (p2_ff.ctl.op == OP_MUL) begin
         st_in[0].s_re  = mq_re.q;
         st_in[0].s_im  = mq_im.q;
         st_in[0].s_sat = mq_re.sat || mq_im.sat;
      end else begin
         st_in[0].s_re  = p2_ff.sub_re.q;
         st_in[0].s_im  = p2_ff.sub_im.q;
         st_in[0].s_sat = p2_ff.sub_re.sat || p2_ff.sub_im.sat;
      end
      st_in[0].neg_re = p2_ff.nre[PW-1];
      st_in[0].neg_im = p2_ff.nim[PW-1];
      // A quotient of 2^33 or more saturates whatever the sign.
      st_in[0].ovf_re = (DW'(mag_re) << 16) >= (DW'(p2_ff.den) << DIV_QBITS);
      st_in[0].ovf_im = (DW'(mag_im) << 16) >= (DW'(p2_ff.den) << DIV_QBITS);
      st_in[0].rem_re = NW'(mag_re) << 16;
      st_in[0].rem_im = NW'(mag_im) << 16;
      st_in[0].q_re   = '0;
      st_in[0].q_im   = '0;
      st_in[0].den    = p2_ff.den;
      st_in[0].big    = p64 >= (64'd1 << (30 + 2*FRAC_BITS));
      st_in[0].srem   = p64 << (32 - 2*FRAC_BITS);
      st_in[0].root   = '0;
      st_in[0].zero   = p2_ff.zero;
      st_in[0].cx     = p2_ff.cx;
      st_in[0].cy     = p2_ff.cy;
      st_in[0].cz     = p2_ff.cz;
   end

   // Each stage retires one quotient bit of both divisions; the first SQRT_BITS stages
   // also retire one root bit and the first CORDIC_STEPS one rotation of the angle search.
   for (genvar s = 0; s < NSTEP; s++) begin : g_step
      localparam int QB = DIV_QBITS - 1 - s;
      localparam int SB = (s < SQRT_BITS) ? SQRT_BITS - 1 - s : 0;
      localparam int CI = (s < 32) ? s : 31;

      always_comb begin
         loop_type       c;
         logic [DW-1:0]  trial;
         logic [63:0]    tsq;
         logic signed [CW-1:0] dx, dy;
         c = st_ff[s];
         st_in[s+1] = c;
         trial = DW'(c.den) << QB;
         if (DW'(c.rem_re) >= trial) begin
            st_in[s+1].rem_re   = NW'(DW'(c.rem_re) - trial);
            st_in[s+1].q_re[QB] = 1'b1;
         end
         if (DW'(c.rem_im) >= trial) begin
            st_in[s+1].rem_im   = NW'(DW'(c.rem_im) - trial);
            st_in[s+1].q_im[QB] = 1'b1;
         end
         tsq = (64'(c.root) << (SB + 1)) + (64'd1 << (2*SB));
         if ((s < SQRT_BITS) && (c.srem >= tsq)) begin
            st_in[s+1].srem     = c.srem - tsq;
            st_in[s+1].root[SB] = 1'b1;
         end
         dx = c.cy >>> s;
         dy = c.cx >>> s;
         if (s < CORDIC_STEPS) begin
            if (!c.cy[CW-1]) begin
               st_in[s+1].cx = c.cx + dx;
               st_in[s+1].cy = c.cy - dy;
               st_in[s+1].cz = c.cz + ATAN_TAB[CI];
            end else begin
               st_in[s+1].cx = c.cx - dx;
               st_in[s+1].cy = c.cy + dy;
               st_in[s+1].cz = c.cz - ATAN_TAB[CI];
            end
         end
      end

      always_ff @(posedge clock) begin
         st_ff[s+1] <= st_in[s+1];
      end
   end

   // Result selection and final saturation of the quotients.
   always_comb begin
      loop_type    f;
      logic        sat_re, sat_im;
      f = st_ff[NSTEP];
      sat_re = f.ovf_re || (f.neg_re ? (f.q_re > 33'h0_8000_0000) : (f.q_re > 33'h0_7FFF_FFFF));
      sat_im = f.ovf_im || (f.neg_im ? (f.q_im > 33'h0_8000_0000) : (f.q_im > 33'h0_7FFF_FFFF));
      re_in  = '0;
      im_in  = '0;
      dif_in = 1'b0;
      sts_in = STATUS_OK;
      unique case (f.ctl.op) inside
         OP_SUB, OP_MUL: begin
            re_in  = f.s_re;
            im_in  = f.s_im;
            sts_in = f.s_sat ? STATUS_SAT : STATUS_OK;
         end
         OP_DIV: begin
            if (f.ctl.dz) begin
               sts_in = STATUS_DIV_ZERO;
            end else begin
               if (sat_re) re_in = f.neg_re ? 32'h8000_0000 : 32'h7FFF_FFFF;
               else re_in = f.neg_re ? 32'd0 - f.q_re[31:0] : f.q_re[31:0];
               if (sat_im) im_in = f.neg_im ? 32'h8000_0000 : 32'h7FFF_FFFF;
               else im_in = f.neg_im ? 32'd0 - f.q_im[31:0] : f.q_im[31:0];
               sts_in = (sat_re || sat_im) ? STATUS_SAT : STATUS_OK;
            end
         end
         OP_POLAR: begin
            re_in  = f.big ? 32'h7FFF_FFFF : {1'b0, f.root};
            im_in  = f.zero ? 32'd0 : f.cz;
            sts_in = f.big ? STATUS_SAT : STATUS_OK;
         end
         OP_NE: begin
            dif_in = f.ctl.differs;
         end
         default: begin
            re_in = '0;
         end
      endcase
   end

   assign vld_in = {vld_ff[VW-2:0], in_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      p1_ff    <= p1_in;
      p2_ff    <= p2_in;
      st_ff[0] <= st_in[0];
      re_ff    <= re_in;
      im_ff    <= im_in;
      dif_ff   <= dif_in;
      sts_ff   <= sts_in;
   end

   assign rsp_valid   = vld_ff[VW-1];
   assign rsp_res_re  = re_ff;
   assign rsp_res_im  = im_ff;
   assign rsp_differs = dif_ff;
   assign rsp_status  = sts_ff;

endmodule

>>> sv/complex_arithmetic_unit.sv
// Complex-number ALU: subtract, multiply, divide, polar form and inequality.
// A result strobes on rsp_valid after its item passes the front register, the queue,
// the p1, p2 and st_ff[0] registers, the 33-stage quotient pipeline and the result register.
// Throughput: one item per cycle while busy is low; the result port cannot be stalled.
// Reset (synchronous) empties the front register, queue and pipeline.
module complex_arithmetic_unit #(
   parameter int IN_WIDTH     = 16,
   parameter int FRAC_BITS    = 8,
   parameter int CORDIC_STEPS = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  logic [2:0]                 req_cmd,
   input  logic signed [IN_WIDTH-1:0] req_a_re,
   input  logic signed [IN_WIDTH-1:0] req_a_im,
   input  logic signed [IN_WIDTH-1:0] req_b_re,
   input  logic signed [IN_WIDTH-1:0] req_b_im,
   output logic                       rsp_valid,
   output logic [31:0]                rsp_res_re,
   output logic [31:0]                rsp_res_im,
   output logic                       rsp_differs,
   output logic [1:0]                 rsp_status
);
   import cau_pkg::*;

   localparam int CTLW = $bits(ctl_type);
   localparam int QW   = CTLW + 4*IN_WIDTH;

   logic                  push, q_full, pop_valid;
   ctl_type               push_ctl, q_ctl;
   logic [4*IN_WIDTH-1:0] push_opnd;
   logic [QW-1:0]         pop_data;

   cau_front #(.IN_WIDTH(IN_WIDTH)) u_front (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_cmd   (req_cmd),
      .req_a_re  (req_a_re),
      .req_a_im  (req_a_im),
      .req_b_re  (req_b_re),
      .req_b_im  (req_b_im),
      .q_full    (q_full),
      .push      (push),
      .push_ctl  (push_ctl),
      .push_opnd (push_opnd)
   );

   cau_queue #(.WIDTH(QW)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data ({push_ctl, push_opnd}),
      .full      (q_full),
      .pop_valid (pop_valid),
      .pop_data  (pop_data)
   );

   assign q_ctl = ctl_type'(pop_data[QW-1 -: CTLW]);

   cau_back #(
      .IN_WIDTH     (IN_WIDTH),
      .FRAC_BITS    (FRAC_BITS),
      .CORDIC_STEPS (CORDIC_STEPS)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (pop_valid),
      .in_ctl      (q_ctl),
      .in_opnd     (pop_data[4*IN_WIDTH-1:0]),
      .rsp_valid   (rsp_valid),
      .rsp_res_re  (rsp_res_re),
      .rsp_res_im  (rsp_res_im),
      .rsp_differs (rsp_differs),
      .rsp_status  (rsp_status)
   );

endmodule

>>> verif/tb.sv
module tb;
   import cau_pkg::*;

   // Codes outside the defined set; the block must answer them with all zeros.
   localparam logic [2:0] CMD_RSVD5 = 3'd5;
   localparam logic [2:0] CMD_RSVD6 = 3'd6;
   localparam logic [2:0] CMD_RSVD7 = 3'd7;

   localparam int RANDOM_ITEMS = 1750;
   localparam int STALL_LIMIT  = 2000;
   localparam int DRAIN_CYCLES = 60;

   typedef struct packed {
      logic [31:0] re;
      logic [31:0] im;
      logic        differs;
      logic [1:0]  status;
   } cau_result_type;

   typedef struct {
      logic [2:0]         cmd;
      logic signed [15:0] ar;
      logic signed [15:0] ai;
      logic signed [15:0] br;
      logic signed [15:0] bi;
      bit                 typed;
      cau_result_type     res;
   } stim_row_type;

   logic               clock;
   logic               reset;
   logic               start;
   logic               busy;
   logic [2:0]         req_cmd;
   logic signed [15:0] req_a_re;
   logic signed [15:0] req_a_im;
   logic signed [15:0] req_b_re;
   logic signed [15:0] req_b_im;
   logic               rsp_valid;
   logic [31:0]        rsp_res_re;
   logic [31:0]        rsp_res_im;
   logic               rsp_differs;
   logic [1:0]         rsp_status;

   // Typed expectation that travels with the item on the request port.
   bit                 row_typed;
   cau_result_type     row_res;

   cau_result_type     pending_results[$];
   int                 errors;
   int                 stall_count;
   int                 idle_pct;

   complex_arithmetic_unit u_top (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_cmd     (req_cmd),
      .req_a_re    (req_a_re),
      .req_a_im    (req_a_im),
      .req_b_re    (req_b_re),
      .req_b_im    (req_b_im),
      .rsp_valid   (rsp_valid),
      .rsp_res_re  (rsp_res_re),
      .rsp_res_im  (rsp_res_im),
      .rsp_differs (rsp_differs),
      .rsp_status  (rsp_status)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic logic [31:0] clamp_q16(input longint v, inout bit sat);
      if (v > 64'sd2147483647) begin
         sat = 1'b1;
         return 32'h7FFF_FFFF;
      end
      if (v < -64'sd2147483648) begin
         sat = 1'b1;
         return 32'h8000_0000;
      end
      return v[31:0];
   endfunction

   // Truncated quotient |num| * 2^16 / den with the sign of num.
   function automatic longint quotient_q16(input longint num, input longint den);
      longint mag;
      longint q;
      mag = (num < 0) ? -num : num;
      if (mag / den > 64'sd2147483648) q = 64'sd4294967296;
      else q = (mag * 65536) / den;
      return (num < 0) ? -q : q;
   endfunction

   function automatic longint floor_sqrt(input longint unsigned n);
      longint unsigned res;
      longint unsigned bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > n) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (n >= res + bitv) begin
            n = n - (res + bitv);
            res = (res >> 1) + bitv;
         end else begin
            res = res >> 1;
         end
         bitv = bitv >> 2;
      end
      return res;
   endfunction

   function automatic longint vector_angle(input longint x, input longint y);
      longint z;
      longint t;
      longint dx;
      longint dy;
      z = 0;
      if (x == 0 && y == 0) return 0;
      // Rotate the left half plane by a quarter turn first.
      if (x < 0) begin
         t = x;
         if (y >= 0) begin
            x = y;
            y = -t;
            z = HALF_PI_Q16;
         end else begin
            x = -y;
            y = t;
            z = -HALF_PI_Q16;
         end
      end
      x = x * 65536;
      y = y * 65536;
      for (int i = 0; i < 16; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (y >= 0) begin
            x = x + dx;
            y = y - dy;
            z = z + ATAN_TAB[i];
         end else begin
            x = x - dx;
            y = y + dy;
            z = z - ATAN_TAB[i];
         end
      end
      return z;
   endfunction

   function automatic cau_result_type predict_result(input logic [2:0] cmd,
                                                     input logic signed [15:0] a_re,
                                                     input logic signed [15:0] a_im,
                                                     input logic signed [15:0] b_re,
                                                     input logic signed [15:0] b_im);
      cau_result_type r;
      longint ar;
      longint ai;
      longint br;
      longint bi;
      longint den;
      bit sat;
      ar = a_re;
      ai = a_im;
      br = b_re;
      bi = b_im;
      r = '0;
      sat = 1'b0;
      case (cmd)
         CMD_SUB: begin
            r.re = clamp_q16((ar - br) * 256, sat);
            r.im = clamp_q16((ai - bi) * 256, sat);
         end
         CMD_MUL: begin
            r.re = clamp_q16(ar * br - ai * bi, sat);
            r.im = clamp_q16(ar * bi + ai * br, sat);
         end
         CMD_DIV: begin
            den = br * br + bi * bi;
            if (den == 0) begin
               r.status = STATUS_DIV_ZERO;
            end else begin
               r.re = clamp_q16(quotient_q16(ar * br + ai * bi, den), sat);
               r.im = clamp_q16(quotient_q16(ai * br - ar * bi, den), sat);
            end
         end
         CMD_POLAR: begin
            r.re = 32'(floor_sqrt((ar * ar + ai * ai) << 16));
            r.im = 32'(vector_angle(ar, ai));
         end
         CMD_NE: begin
            r.differs = (ar != br) || (ai != bi);
         end
         default: begin
         end
      endcase
      if (sat && r.status == STATUS_OK) r.status = STATUS_SAT;
      return r;
   endfunction

   function automatic logic signed [15:0] random_operand();
      case ($urandom_range(0, 9))
         0: return -16'sd32768;
         1: return 16'sd32767;
         2: return 16'sd0;
         3, 4, 5: return 16'($signed($urandom_range(0, 1023)) - 512);
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic stim_row_type random_row();
      stim_row_type r;
      r.typed = 1'b0;
      r.res = '0;
      r.cmd = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(5, 7))
                                           : 3'($urandom_range(0, 4));
      r.ar = random_operand();
      r.ai = random_operand();
      r.br = random_operand();
      r.bi = random_operand();
      if (r.cmd == CMD_DIV && $urandom_range(0, 7) == 0) begin
         r.br = '0;
         r.bi = '0;
      end
      if (r.cmd == CMD_NE) begin
         case ($urandom_range(0, 3))
            0: begin
               r.br = r.ar;
               r.bi = r.ai;
            end
            1: r.br = r.ar;
            2: r.bi = r.ai;
            default: begin
            end
         endcase
      end
      return r;
   endfunction

   task automatic drive_item(input stim_row_type r);
      int gap;
      start     <= 1'b1;
      req_cmd   <= r.cmd;
      req_a_re  <= r.ar;
      req_a_im  <= r.ai;
      req_b_re  <= r.br;
      req_b_im  <= r.bi;
      row_typed <= r.typed;
      row_res   <= r.res;
      @(posedge clock);
      while (busy) @(posedge clock);
      if ($urandom_range(0, 99) < idle_pct) begin
         gap = $urandom_range(1, 5);
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Request monitor, result checker and watchdog.
   always @(posedge clock) begin
      cau_result_type exp_r;
      if (!reset) begin
         if (start && !busy) begin
            stall_count <= 0;
            if (row_typed) exp_r = row_res;
            else exp_r = predict_result(req_cmd, req_a_re, req_a_im, req_b_re, req_b_im);
            pending_results.push_back(exp_r);
         end else if (rsp_valid) begin
            stall_count <= 0;
         end else begin
            stall_count <= stall_count + 1;
         end
         if (rsp_valid) begin
            if (pending_results.size() == 0) begin
               $display("%0t: result with nothing expected: re %h im %h differs %b status %0d",
                        $time, rsp_res_re, rsp_res_im, rsp_differs, rsp_status);
               errors <= errors + 1;
            end else begin
               exp_r = pending_results.pop_front();
               if (rsp_res_re !== exp_r.re || rsp_res_im !== exp_r.im ||
                   rsp_differs !== exp_r.differs || rsp_status !== exp_r.status) begin
                  $display("%0t: mismatch expected re %h im %h differs %b status %0d",
                           $time, exp_r.re, exp_r.im, exp_r.differs, exp_r.status);
                  $display("%0t:          actual   re %h im %h differs %b status %0d",
                           $time, rsp_res_re, rsp_res_im, rsp_differs, rsp_status);
                  errors <= errors + 1;
               end
            end
         end
         if (stall_count >= STALL_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
         end
      end
   end

   initial begin
      stim_row_type rows[$];
      stim_row_type r;
      int phase_pct[4];
      phase_pct = '{0, 54, 0, 34};
      errors      = 0;
      stall_count = 0;
      idle_pct    = 0;
      reset     = 1'b1;
      start     = 1'b0;
      req_cmd   = CMD_SUB;
      req_a_re  = 0;
      req_a_im  = 0;
      req_b_re  = 0;
      req_b_im  = 0;
      row_typed = 1'b0;
      row_res   = '0;

      rows.push_back('{CMD_SUB, 0, 0, 0, 0, 1, '{32'd0, 32'd0, 1'b0, STATUS_OK}});
      rows.push_back('{CMD_SUB, 32767, -32768, -32768, 32767, 1,
                       '{32'sd16776960, -32'sd16776960, 1'b0, STATUS_OK}});
      rows.push_back('{CMD_SUB, -32768, 32767, 32767, -32768, 0, '0});
      rows.push_back('{CMD_MUL, -32768, 0, -32768, 0, 1,
                       '{32'h4000_0000, 32'd0, 1'b0, STATUS_OK}});
      // Imaginary part reaches +2^31 and saturates.
      rows.push_back('{CMD_MUL, -32768, -32768, -32768, -32768, 1,
                       '{32'd0, 32'h7FFF_FFFF, 1'b0, STATUS_SAT}});
      rows.push_back('{CMD_MUL, -32768, 32767, -32768, -32768, 0, '0});
      rows.push_back('{CMD_MUL, 32767, 32767, 32767, -32768, 0, '0});
      rows.push_back('{CMD_DIV, 256, 256, 0, 0, 1, '{32'd0, 32'd0, 1'b0, STATUS_DIV_ZERO}});
      rows.push_back('{CMD_DIV, 256, 0, 256, 0, 1, '{32'd65536, 32'd0, 1'b0, STATUS_OK}});
      rows.push_back('{CMD_DIV, -32768, 0, -1, 0, 1,
                       '{32'h7FFF_FFFF, 32'd0, 1'b0, STATUS_SAT}});
      rows.push_back('{CMD_DIV, -32768, 0, 1, 0, 0, '0});
      rows.push_back('{CMD_DIV, 32767, -32768, -32768, 32767, 0, '0});
      rows.push_back('{CMD_POLAR, 0, 0, 5, 5, 1, '{32'd0, 32'd0, 1'b0, STATUS_OK}});
      rows.push_back('{CMD_POLAR, 256, 0, 0, 0, 0, '0});
      rows.push_back('{CMD_POLAR, -256, 0, 0, 0, 0, '0});
      rows.push_back('{CMD_POLAR, 0, 256, 0, 0, 0, '0});
      rows.push_back('{CMD_POLAR, 0, -256, 0, 0, 0, '0});
      rows.push_back('{CMD_POLAR, -32768, -32768, 0, 0, 0, '0});
      rows.push_back('{CMD_POLAR, 32767, 32767, 0, 0, 0, '0});
      rows.push_back('{CMD_NE, -32768, 32767, -32768, 32767, 1,
                       '{32'd0, 32'd0, 1'b0, STATUS_OK}});
      rows.push_back('{CMD_NE, 100, 5, 100, 6, 1, '{32'd0, 32'd0, 1'b1, STATUS_OK}});
      rows.push_back('{CMD_RSVD5, 1, 2, 3, 4, 1, '{32'd0, 32'd0, 1'b0, STATUS_OK}});
      rows.push_back('{CMD_RSVD6, -1, -1, 0, 0, 1, '{32'd0, 32'd0, 1'b0, STATUS_OK}});
      rows.push_back('{CMD_RSVD7, 32767, 0, 0, 0, 1, '{32'd0, 32'd0, 1'b0, STATUS_OK}});

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (rows[i]) drive_item(rows[i]);
      for (int p = 0; p < 4; p++) begin
         idle_pct = phase_pct[p];
         for (int n = 0; n < RANDOM_ITEMS / 4; n++) begin
            r = random_row();
            drive_item(r);
         end
      end
      start <= 1'b0;

      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (errors == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
